>>> hdl/assert_macros.svh
// Assertion macros shared by the bar meter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define SBPH_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define SBPH_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/sbph_pkg.sv
// Types, constants and register codes of the spectrum bar meter
`default_nettype none

package sbph_pkg;

   localparam int SBPH_BANDS  = 64;
   localparam int BAR_WIDTH   = 3;
   localparam int BAR_GAP     = 1;
   localparam int BAR_PITCH   = BAR_WIDTH + BAR_GAP;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_W     = 8;
   localparam int WORD_W      = 2 * LEVEL_W;

   localparam logic        RST_DISPLAY_ENABLED = 1'b1;
   localparam logic [7:0]  RST_SEG_SIZE        = 8'd36;
   localparam logic [9:0]  RST_AREA_HEIGHT     = 10'd240;
   localparam logic [15:0] RST_LOW_COLOR       = 16'h07E0;
   localparam logic [15:0] RST_MEDIUM_COLOR    = 16'hFFE0;
   localparam logic [15:0] RST_HIGH_COLOR      = 16'hF800;
   localparam logic [15:0] RST_PEAK_COLOR      = 16'h07FF;
   localparam logic [15:0] RST_BACK_COLOR      = 16'h0000;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_MARKER = 1'b1;

   typedef enum logic [2:0] {
      CSR_DISPLAY_ENABLED,
      CSR_SEG_SIZE,
      CSR_AREA_HEIGHT,
      CSR_LOW_COLOR,
      CSR_MEDIUM_COLOR,
      CSR_HIGH_COLOR,
      CSR_PEAK_COLOR,
      CSR_BACK_COLOR
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_ERASE,
      PH_BACK,
      PH_LOW,
      PH_MED,
      PH_HIGH
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic       channel;
      logic [5:0] band;
      logic [7:0] level;
   } req_item_type;

   typedef struct packed {
      logic [7:0]         rect_x;
      logic signed [11:0] rect_y;
      logic [1:0]         rect_width;
      logic [7:0]         rect_rows;
      logic [15:0]        rect_color;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      csr_index_type reg_index;
      logic [15:0]   wr_data;
   } csr_write_type;

   typedef struct packed {
      logic        display_enabled;
      logic [7:0]  seg_size;
      logic [9:0]  area_height;
      logic [15:0] low_color;
      logic [15:0] medium_color;
      logic [15:0] high_color;
      logic [15:0] peak_color;
      logic [15:0] back_color;
   } cfg_type;

   // One classified item waiting for the draw sequencer
   typedef struct packed {
      logic               marker;
      logic               channel;
      logic [5:0]         band;
      logic [LEVEL_W-1:0] peak;
      logic [LEVEL_W-1:0] now_level;
      logic [LEVEL_W-1:0] next_level;
      logic               falling;
   } cmd_entry_type;

endpackage

`default_nettype wire

>>> hdl/sbph_chan_if.sv
// Valid/ready channel interface carrying one item type
`default_nettype none

interface sbph_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/sbph_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module sbph_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/sbph_queue.sv
// Short queue of classified items between the front and the draw sequencer
`default_nettype none
`include "assert_macros.svh"

module sbph_queue import sbph_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmd_entry_type     push_entry,
   input  logic              pop,
   output logic              head_valid,
   output cmd_entry_type     head_entry,
   output logic [QCNT_W-1:0] count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_entry_type     entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

   `SBPH_ASSERT_SAME(a_no_push_full, push, count_ff != QCNT_W'(QUEUE_DEPTH), "push into full queue")
   `SBPH_ASSERT_SAME(a_no_pop_empty, pop, count_ff != '0, "pop from empty queue")

endmodule

`default_nettype wire

>>> hdl/sbph_front.sv
// Front end: accepts items, updates level and peak store, classifies for drawing
`default_nettype none
`include "assert_macros.svh"

module sbph_front import sbph_pkg::*; #(
   parameter int BANDS = SBPH_BANDS
) (
   input  logic              clock,
   input  logic              reset,
   sbph_chan_if.sink         req,
   input  cfg_type           cfg,
   input  logic [QCNT_W-1:0] q_count,
   output logic              push,
   output cmd_entry_type     push_entry
);

   localparam int DEPTH = 2 * BANDS;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(DEPTH - 1);

   logic               clr_active_ff;
   logic [IDX_W-1:0]   clr_addr_ff;
   logic               accept;
   logic               in_range;
   logic [IDX_W-1:0]   idx_in;
   logic               b_valid_ff;
   req_item_type       b_item_ff;
   logic [IDX_W-1:0]   b_idx_ff;
   logic               fwd_valid_ff;
   logic [IDX_W-1:0]   fwd_idx_ff;
   logic [WORD_W-1:0]  fwd_data_ff;
   logic [WORD_W-1:0]  rd_data;
   logic [WORD_W-1:0]  b_word;
   logic [LEVEL_W-1:0] b_peak;
   logic [LEVEL_W-1:0] b_now;
   logic [LEVEL_W-1:0] new_peak;
   logic               item_wr;
   logic [WORD_W-1:0]  item_word;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;

   // Room for the item in stage B plus the new one
   assign req.ready = !clr_active_ff &&
      (({1'b0, q_count} + (QCNT_W + 1)'(b_valid_ff)) < (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept   = req.valid && req.ready;
   assign in_range = int'(req.data.band) < BANDS;
   assign idx_in   = req.data.channel ? IDX_W'(BANDS + int'(req.data.band))
                                      : IDX_W'(req.data.band);

   sbph_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == CLR_LAST) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         // drop bands outside the store here
         b_valid_ff <= accept && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_item_ff <= req.data;
         b_idx_ff  <= idx_in;
      end
   end

   // Take the last written word when the store read raced with that write
   always_comb begin
      if (fwd_valid_ff && fwd_idx_ff == b_idx_ff) begin
         b_word = fwd_data_ff;
      end else begin
         b_word = rd_data;
      end
      b_peak = b_word[WORD_W-1:LEVEL_W];
      b_now  = b_word[LEVEL_W-1:0];
      if (b_peak < b_item_ff.level) begin
         new_peak = b_item_ff.level;
      end else if (b_peak != '0) begin
         new_peak = b_peak - LEVEL_W'(1);
      end else begin
         new_peak = '0;
      end
   end

   assign item_wr   = b_valid_ff && (b_item_ff.req_type == REQ_SAMPLE);
   assign item_word = cfg.display_enabled ? {new_peak, b_item_ff.level}
                                          : {b_peak, b_item_ff.level};
   assign wr_en     = clr_active_ff || item_wr;
   assign wr_addr   = clr_active_ff ? clr_addr_ff : b_idx_ff;
   assign wr_data   = clr_active_ff ? '0 : item_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (clr_active_ff) begin
         fwd_valid_ff <= 1'b0;
      end else if (item_wr) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (item_wr) begin
         fwd_idx_ff  <= b_idx_ff;
         fwd_data_ff <= item_word;
      end
   end

   assign push = b_valid_ff && cfg.display_enabled;

   always_comb begin
      push_entry.marker     = (b_item_ff.req_type == REQ_MARKER);
      push_entry.channel    = b_item_ff.channel;
      push_entry.band       = b_item_ff.band;
      push_entry.peak       = b_peak;
      push_entry.now_level  = b_now;
      push_entry.next_level = b_item_ff.level;
      push_entry.falling    = (b_now >= b_item_ff.level);
   end

   `SBPH_ASSERT_NEXT(a_clear_ends, clr_active_ff && clr_addr_ff == CLR_LAST, !clr_active_ff, "clear pass overran")
   `SBPH_ASSERT_SAME(a_no_item_in_clear, clr_active_ff, !b_valid_ff, "item in flight during clear pass")

endmodule

`default_nettype wire

>>> hdl/sbph_back.sv
// Back end: sequences rectangle commands for each queued item
`default_nettype none
`include "assert_macros.svh"

module sbph_back import sbph_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          head_valid,
   input  cmd_entry_type head,
   output logic          pop,
   sbph_chan_if.source   rsp
);

   phase_type    phase_ff;
   phase_type    phase_in;
   phase_type    cur_phase;
   phase_type    after_phase;
   logic         rsp_valid_ff;
   rsp_item_type rsp_data_ff;
   rsp_item_type cmd;
   logic         load;
   logic [11:0]  base_up_ff;
   logic [11:0]  base_down_ff;
   logic [11:0]  three_s;
   logic [11:0]  s12;
   logic [11:0]  two_s12;
   logic [11:0]  pk12;
   logic [11:0]  now12;
   logic [11:0]  next12;
   logic [7:0]   low8;
   logic [7:0]   med8;
   logic [7:0]   hi8;
   logic [11:0]  y12;

   assign s12     = 12'(cfg.seg_size);
   assign two_s12 = {s12[10:0], 1'b0};
   assign three_s = two_s12 + s12;

   // Base rows follow registers; user sets those only while idle, unchecked
   always_ff @(posedge clock) begin
      base_up_ff   <= three_s + 12'd1;
      base_down_ff <= 12'(cfg.area_height) - three_s - 12'd1;
   end

   assign load = head_valid && (!rsp_valid_ff || rsp.ready);
   assign pop  = load && cmd.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      pk12   = 12'(head.peak);
      now12  = 12'(head.now_level);
      next12 = 12'(head.next_level);
      low8   = (head.next_level > cfg.seg_size) ? cfg.seg_size : head.next_level;
      med8   = ({1'b0, head.next_level} > {cfg.seg_size, 1'b0}) ? cfg.seg_size
               : head.next_level - cfg.seg_size;
      hi8    = 8'({1'b0, head.next_level} - {cfg.seg_size, 1'b0});

      if (phase_ff != PH_START) begin
         cur_phase = phase_ff;
      end else if (head.marker || head.peak != '0) begin
         cur_phase = PH_ERASE;
      end else if (head.falling) begin
         cur_phase = PH_BACK;
      end else begin
         cur_phase = PH_LOW;
      end

      cmd.rect_x     = 8'(14'(head.band) * 14'(BAR_PITCH));
      cmd.rect_width = 2'(BAR_WIDTH);
      y12            = '0;
      cmd.rect_rows  = '0;
      cmd.rect_color = cfg.back_color;
      cmd.last       = 1'b1;
      after_phase    = PH_START;

      case (cur_phase)
         PH_ERASE: begin
            y12 = head.channel ? base_down_ff + pk12 : base_up_ff - pk12 - 12'd1;
            cmd.rect_rows  = 8'd1;
            cmd.rect_color = head.marker ? cfg.peak_color : cfg.back_color;
            cmd.last       = head.marker;
            after_phase    = head.falling ? PH_BACK : PH_LOW;
         end
         PH_BACK: begin
            y12 = head.channel ? base_down_ff + next12 : base_up_ff - now12;
            cmd.rect_rows  = head.now_level - head.next_level;
            cmd.rect_color = cfg.back_color;
            cmd.last       = 1'b1;
         end
         PH_LOW: begin
            y12 = head.channel ? base_down_ff : base_up_ff - 12'(low8);
            cmd.rect_rows  = low8;
            cmd.rect_color = cfg.low_color;
            cmd.last       = (low8 != cfg.seg_size);
            after_phase    = PH_MED;
         end
         PH_MED: begin
            y12 = head.channel ? base_down_ff + s12 : base_up_ff - s12 - 12'(med8);
            cmd.rect_rows  = med8;
            cmd.rect_color = cfg.medium_color;
            cmd.last       = (med8 != cfg.seg_size);
            after_phase    = PH_HIGH;
         end
         PH_HIGH: begin
            y12 = head.channel ? base_down_ff + two_s12 : base_up_ff - next12;
            cmd.rect_rows  = hi8;
            cmd.rect_color = cfg.high_color;
            cmd.last       = 1'b1;
         end
         default: begin
            y12 = '0;
         end
      endcase
      cmd.rect_y = $signed(y12);

      phase_in = phase_ff;
      if (load) begin
         phase_in = cmd.last ? PH_START : after_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= cmd;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   `SBPH_ASSERT_NEXT(a_pop_on_last, pop, rsp_valid_ff && rsp_data_ff.last, "item retired without last command")
   `SBPH_ASSERT_SAME(a_head_held, phase_ff != PH_START, head_valid, "sequencer mid-item with empty queue")

endmodule

`default_nettype wire

>>> hdl/spectrum_bar_peak_hold_renderer_unit.sv
// Top level of the spectrum bar meter with peak hold, emitting rectangle commands.
// Path: an accepted item is registered in stage B, the queue and the command register.
// Throughput: one command per cycle while an item is queued and rsp is ready; a sample
// item gives 1 to 4, a marker 1 (display on), so the draw sequencer sets the item rate.
// Reset: registers take their defaults; a clearing pass over all 2*BANDS words zeroes the
// level and peak store, and no item is accepted until it ends.
`default_nettype none

module spectrum_bar_peak_hold_renderer_unit import sbph_pkg::*; #(
   parameter int BANDS = SBPH_BANDS
) (
   input  logic        clock,
   input  logic        reset,
   sbph_chan_if.sink   req_ch,
   sbph_chan_if.source rsp_ch,
   sbph_chan_if.sink   csr_ch
);

   cfg_type           cfg_ff;
   logic              push;
   cmd_entry_type     push_entry;
   logic              pop;
   logic              head_valid;
   cmd_entry_type     head_entry;
   logic [QCNT_W-1:0] q_count;
   csr_write_type     csr_wr;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_enabled <= RST_DISPLAY_ENABLED;
         cfg_ff.seg_size        <= RST_SEG_SIZE;
         cfg_ff.area_height     <= RST_AREA_HEIGHT;
         cfg_ff.low_color       <= RST_LOW_COLOR;
         cfg_ff.medium_color    <= RST_MEDIUM_COLOR;
         cfg_ff.high_color      <= RST_HIGH_COLOR;
         cfg_ff.peak_color      <= RST_PEAK_COLOR;
         cfg_ff.back_color      <= RST_BACK_COLOR;
      end else if (csr_ch.valid) begin
         case (csr_wr.reg_index)
            CSR_DISPLAY_ENABLED: cfg_ff.display_enabled <= csr_wr.wr_data[0];
            CSR_SEG_SIZE:        cfg_ff.seg_size        <= csr_wr.wr_data[7:0];
            CSR_AREA_HEIGHT:     cfg_ff.area_height     <= csr_wr.wr_data[9:0];
            CSR_LOW_COLOR:       cfg_ff.low_color       <= csr_wr.wr_data;
            CSR_MEDIUM_COLOR:    cfg_ff.medium_color    <= csr_wr.wr_data;
            CSR_HIGH_COLOR:      cfg_ff.high_color      <= csr_wr.wr_data;
            CSR_PEAK_COLOR:      cfg_ff.peak_color      <= csr_wr.wr_data;
            CSR_BACK_COLOR:      cfg_ff.back_color      <= csr_wr.wr_data;
            default: begin
            end
         endcase
      end
   end

   sbph_front #(
      .BANDS (BANDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg_ff),
      .q_count    (q_count),
      .push       (push),
      .push_entry (push_entry)
   );

   sbph_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .count      (q_count)
   );

   sbph_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head_entry),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking bench for the spectrum bar meter: drives band items, checks rectangle commands
module tb;
   import sbph_pkg::*;

   logic clock;
   logic reset;

   sbph_chan_if #(.payload_type(req_item_type))  req_if ();
   sbph_chan_if #(.payload_type(rsp_item_type))  rsp_if ();
   sbph_chan_if #(.payload_type(csr_write_type)) csr_if ();

   spectrum_bar_peak_hold_renderer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Shadow of the block: settings, bar levels and peak hold per channel and band
   cfg_type      shadow_cfg;
   logic [7:0]   bar_level [2*SBPH_BANDS];
   logic [7:0]   peak_hold [2*SBPH_BANDS];

   req_item_type pending_items [$];
   rsp_item_type rects_due [$];

   bit           req_taken;
   bit           gaps_on;
   bit           stalls_on;
   int           gap_left;
   int           stall_left;
   int           items_sent;
   int           rects_checked;
   int           reg_writes;
   int           errors;
   rsp_item_type want;
   rsp_item_type got;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int pick_pause(bit on);
      int r;
      r = $urandom_range(0, 99);
      if (!on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic rsp_item_type rect_of(logic [7:0] x, int y, int h, logic [15:0] color);
      rsp_item_type r;
      r.rect_x     = x;
      r.rect_y     = 12'(y);
      r.rect_width = 2'(BAR_WIDTH);
      r.rect_rows  = 8'(h);
      r.rect_color = color;
      r.last       = 1'b0;
      return r;
   endfunction

   // Work out the rectangles one item draws and update the shadow state
   function automatic void plan_rects(req_item_type it);
      logic [6:0]   slot;
      logic [7:0]   x;
      int           s, base_up, base_down, pk, now_lv, next_lv, low, med, hi, n;
      rsp_item_type drawn [4];
      slot = {it.channel, it.band};
      n = 0;
      if (!shadow_cfg.display_enabled) begin
         if (it.req_type == REQ_SAMPLE) bar_level[slot] = it.level;
         return;
      end
      s         = int'(shadow_cfg.seg_size);
      base_up   = 3 * s + 1;
      base_down = int'(shadow_cfg.area_height) - 3 * s - 1;
      x         = 8'(int'(it.band) * BAR_PITCH);
      pk        = int'(peak_hold[slot]);
      if (it.req_type == REQ_MARKER) begin
         drawn[0] = rect_of(x, it.channel ? base_down + pk : base_up - pk - 1, 1,
                            shadow_cfg.peak_color);
         n = 1;
      end else begin
         now_lv  = int'(bar_level[slot]);
         next_lv = int'(it.level);
         bar_level[slot] = it.level;
         if (pk != 0) begin
            drawn[n] = rect_of(x, it.channel ? base_down + pk : base_up - pk - 1, 1,
                               shadow_cfg.back_color);
            n++;
         end
         if (pk < next_lv) peak_hold[slot] = it.level;
         else if (pk > 0) peak_hold[slot] = 8'(pk - 1);
         if (now_lv >= next_lv) begin
            // falling or unchanged bar: clear the part above the new level
            drawn[n] = rect_of(x, it.channel ? base_down + next_lv : base_up - now_lv,
                               now_lv - next_lv, shadow_cfg.back_color);
            n++;
         end else begin
            low = (next_lv > s) ? s : next_lv;
            drawn[n] = rect_of(x, it.channel ? base_down : base_up - low, low,
                               shadow_cfg.low_color);
            n++;
            if (low == s) begin
               med = (next_lv > 2 * s) ? s : next_lv - low;
               drawn[n] = rect_of(x, it.channel ? base_down + low : base_up - low - med, med,
                                  shadow_cfg.medium_color);
               n++;
               if (med == s) begin
                  hi = next_lv - 2 * s;
                  drawn[n] = rect_of(x, it.channel ? base_down + low + med
                                                   : base_up - low - med - hi,
                                     hi, shadow_cfg.high_color);
                  n++;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         drawn[i].last = (i == n - 1);
         rects_due.push_back(drawn[i]);
      end
   endfunction

   // Driver: present queued items, hold each until taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_if.data  <= pending_items.pop_front();
            req_if.valid <= 1'b1;
            gap_left = pick_pause(gaps_on);
            items_sent++;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left = pick_pause(stalls_on);
      end
   end

   // Monitor: predict on every accepted item, check every accepted rectangle
   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg = '{RST_DISPLAY_ENABLED, RST_SEG_SIZE, RST_AREA_HEIGHT, RST_LOW_COLOR,
                        RST_MEDIUM_COLOR, RST_HIGH_COLOR, RST_PEAK_COLOR, RST_BACK_COLOR};
         for (int i = 0; i < 2 * SBPH_BANDS; i++) begin
            bar_level[i] = '0;
            peak_hold[i] = '0;
         end
         req_taken = 1'b0;
      end else begin
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) plan_rects(req_if.data);
         if (csr_if.valid && csr_if.ready) begin
            reg_writes++;
            case (csr_if.data.reg_index)
               CSR_DISPLAY_ENABLED: shadow_cfg.display_enabled = csr_if.data.wr_data[0];
               CSR_SEG_SIZE:        shadow_cfg.seg_size        = csr_if.data.wr_data[7:0];
               CSR_AREA_HEIGHT:     shadow_cfg.area_height     = csr_if.data.wr_data[9:0];
               CSR_LOW_COLOR:       shadow_cfg.low_color       = csr_if.data.wr_data;
               CSR_MEDIUM_COLOR:    shadow_cfg.medium_color    = csr_if.data.wr_data;
               CSR_HIGH_COLOR:      shadow_cfg.high_color      = csr_if.data.wr_data;
               CSR_PEAK_COLOR:      shadow_cfg.peak_color      = csr_if.data.wr_data;
               CSR_BACK_COLOR:      shadow_cfg.back_color      = csr_if.data.wr_data;
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (rects_due.size() == 0) begin
               $error("rectangle x=%0d y=%0d arrived with none expected", got.rect_x,
                      got.rect_y);
               errors++;
            end else begin
               want = rects_due.pop_front();
               rects_checked++;
               if (got.rect_x !== want.rect_x) begin
                  $error("rect_x: expected %0d, got %0d", want.rect_x, got.rect_x);
                  errors++;
               end
               if (got.rect_y !== want.rect_y) begin
                  $error("rect_y: expected %0d, got %0d", want.rect_y, got.rect_y);
                  errors++;
               end
               if (got.rect_width !== want.rect_width) begin
                  $error("rect_width: expected %0d, got %0d", want.rect_width,
                         got.rect_width);
                  errors++;
               end
               if (got.rect_rows !== want.rect_rows) begin
                  $error("rect_rows: expected %0d, got %0d", want.rect_rows,
                         got.rect_rows);
                  errors++;
               end
               if (got.rect_color !== want.rect_color) begin
                  $error("rect_color: expected %h, got %h", want.rect_color, got.rect_color);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  errors++;
               end
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      csr_write_type w;
      w.reg_index = idx;
      w.wr_data   = val;
      @(negedge clock);
      csr_if.data  <= w;
      csr_if.valid <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic add_item(input logic kind, input logic ch, input int band, input int lv);
      req_item_type it;
      it.req_type = kind;
      it.channel  = ch;
      it.band     = 6'(band);
      it.level    = 8'(lv);
      pending_items.push_back(it);
   endtask

   // Let all queued items drain, then give the pipeline time to settle
   task automatic wait_idle();
      @(posedge clock);
      while (pending_items.size() != 0 || req_if.valid || rects_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      logic [7:0]   hist [2*SBPH_BANDS];
      logic [6:0]   pool [4];
      logic [6:0]   slot;
      logic [7:0]   lv;
      logic [7:0]   seg_now;
      int           r;
      req_item_type it;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      gaps_on      = 1'b0;
      stalls_on    = 1'b0;
      for (int i = 0; i < 2 * SBPH_BANDS; i++) hist[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: default settings, no idling
      add_item(REQ_MARKER, 1'b0, 0, 0);     // marker with zero peak
      add_item(REQ_SAMPLE, 1'b0, 0, 255);   // full bar, all three segments
      add_item(REQ_MARKER, 1'b0, 0, 0);
      add_item(REQ_SAMPLE, 1'b0, 0, 255);   // unchanged bar: zero-height clear
      add_item(REQ_SAMPLE, 1'b0, 0, 10);    // falling bar
      add_item(REQ_SAMPLE, 1'b1, 63, 72);   // exactly two segments: empty top segment
      add_item(REQ_MARKER, 1'b1, 63, 255);
      add_item(REQ_SAMPLE, 1'b1, 63, 36);
      add_item(REQ_SAMPLE, 1'b1, 63, 36);
      add_item(REQ_SAMPLE, 1'b0, 21, 20);   // low segment only
      add_item(REQ_SAMPLE, 1'b1, 42, 50);   // low and medium
      add_item(REQ_SAMPLE, 1'b0, 63, 0);
      wait_idle();

      // Zero segment size: top segment takes the whole bar
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      write_reg(CSR_SEG_SIZE, 16'h0000);
      write_reg(CSR_AREA_HEIGHT, 16'd1023);
      write_reg(CSR_LOW_COLOR, 16'hFFFF);
      write_reg(CSR_MEDIUM_COLOR, 16'h0000);
      write_reg(CSR_HIGH_COLOR, 16'hAAAA);
      write_reg(CSR_PEAK_COLOR, 16'h5555);
      write_reg(CSR_BACK_COLOR, 16'hFFFF);
      write_reg(CSR_DISPLAY_ENABLED, 16'h0001);
      add_item(REQ_SAMPLE, 1'b0, 5, 200);
      add_item(REQ_SAMPLE, 1'b1, 5, 1);
      add_item(REQ_MARKER, 1'b1, 5, 0);
      wait_idle();

      // Largest segment, smallest area: right channel origin far above the top
      write_reg(CSR_SEG_SIZE, 16'd255);
      write_reg(CSR_AREA_HEIGHT, 16'd8);
      add_item(REQ_SAMPLE, 1'b0, 9, 255);
      add_item(REQ_SAMPLE, 1'b1, 9, 255);
      add_item(REQ_MARKER, 1'b1, 9, 0);
      wait_idle();

      // Display off: levels stored, nothing drawn, peaks held
      write_reg(CSR_DISPLAY_ENABLED, 16'h0000);
      add_item(REQ_SAMPLE, 1'b0, 0, 77);
      add_item(REQ_MARKER, 1'b0, 0, 0);
      add_item(REQ_SAMPLE, 1'b1, 9, 3);
      wait_idle();
      write_reg(CSR_DISPLAY_ENABLED, 16'h0001);
      write_reg(CSR_SEG_SIZE, 16'd1);
      write_reg(CSR_AREA_HEIGHT, 16'd300);
      add_item(REQ_MARKER, 1'b0, 0, 0);
      add_item(REQ_SAMPLE, 1'b0, 0, 77);
      add_item(REQ_SAMPLE, 1'b1, 9, 0);
      wait_idle();
      seg_now = 8'd1;

      // Random phases: bands mostly from a small pool so state carries over
      for (int ph = 0; ph < 5; ph++) begin
         r = $urandom_range(0, 9);
         case (r)
            0:       seg_now = 8'd0;
            1:       seg_now = 8'd1;
            2:       seg_now = 8'd255;
            3:       seg_now = 8'($urandom_range(0, 65535));
            default: seg_now = 8'($urandom_range(2, 60));
         endcase
         if (r == 3) write_reg(CSR_SEG_SIZE, {8'($urandom), seg_now});
         else write_reg(CSR_SEG_SIZE, {8'h00, seg_now});
         r = $urandom_range(0, 9);
         case (r)
            0:       write_reg(CSR_AREA_HEIGHT, 16'd8);
            1:       write_reg(CSR_AREA_HEIGHT, 16'd1023);
            2:       write_reg(CSR_AREA_HEIGHT, 16'($urandom_range(0, 65535)));
            default: write_reg(CSR_AREA_HEIGHT, 16'($urandom_range(100, 600)));
         endcase
         write_reg(CSR_DISPLAY_ENABLED, {15'($urandom), $urandom_range(0, 4) != 0});
         if ($urandom_range(0, 1)) write_reg(CSR_LOW_COLOR, 16'($urandom));
         if ($urandom_range(0, 1)) write_reg(CSR_MEDIUM_COLOR, 16'($urandom));
         if ($urandom_range(0, 1)) write_reg(CSR_HIGH_COLOR, 16'($urandom));
         if ($urandom_range(0, 1)) write_reg(CSR_PEAK_COLOR, 16'($urandom));
         if ($urandom_range(0, 1)) write_reg(CSR_BACK_COLOR, 16'($urandom));
         gaps_on   = $urandom_range(0, 2) != 0;
         stalls_on = $urandom_range(0, 2) != 0;
         for (int k = 0; k < 4; k++) pool[k] = 7'($urandom);
         for (int k = 0; k < 17; k++) begin
            slot = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 3)] : 7'($urandom);
            case ($urandom_range(0, 7))
               0:       lv = 8'd0;
               1:       lv = 8'd255;
               2:       lv = hist[slot];
               3:       lv = seg_now;
               4:       lv = 8'(2 * seg_now);
               5:       lv = 8'(hist[slot] - 1);
               default: lv = 8'($urandom);
            endcase
            it.req_type = ($urandom_range(0, 4) == 0) ? REQ_MARKER : REQ_SAMPLE;
            it.channel  = slot[6];
            it.band     = slot[5:0];
            it.level    = (it.req_type == REQ_MARKER) ? 8'($urandom) : lv;
            if (it.req_type == REQ_SAMPLE) hist[slot] = lv;
            pending_items.push_back(it);
         end
         wait_idle();
      end

      $display("Sent %0d band items, checked %0d rectangles, %0d register writes",
               items_sent, rects_checked, reg_writes);
      $display("Covered segment sizes 0 to 255, display on and off, both channels");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
